// ===== src/ultrasonic_range_zone_classifier_unit_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef ULTRASONIC_RANGE_ZONE_CLASSIFIER_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGE_ZONE_CLASSIFIER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URZC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URZC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/urzc_pkg.sv =====
package urzc_pkg;

	localparam int ECHO_COUNT_BITS = 16;
	localparam int TICK_BITS = 4;
	localparam int CFG_BITS = 10;
	localparam int CFG_IDX_BITS = 2;
	localparam int DIST_BITS = 11;
	localparam int CM_DIVISOR = 58;
	localparam int REM_BITS = $clog2(CM_DIVISOR);
	localparam int DANGER_MARGIN = 5;

	localparam logic [TICK_BITS-1:0] TRIG_LOW_TICKS = TICK_BITS'(2);
	localparam logic [TICK_BITS-1:0] TRIG_HIGH_TICKS = TICK_BITS'(10);
	localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam logic [REM_BITS-1:0] REM_LAST = REM_BITS'(CM_DIVISOR - 1);

	localparam logic [CFG_BITS-1:0] STOP_RESET = CFG_BITS'(20);
	localparam logic [CFG_BITS-1:0] SLOW_RESET = CFG_BITS'(50);
	localparam logic [CFG_BITS-1:0] ONWARD_RESET = CFG_BITS'(100);

	localparam logic [CFG_IDX_BITS-1:0] CFG_STOP = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_ONWARD = CFG_IDX_BITS'(2);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TLOW,
		PH_THIGH,
		PH_WAIT,
		PH_COUNT
	} phase_t;

	typedef enum logic [2:0] {
		ZONE_NONE,
		ZONE_DANGER,
		ZONE_STOP,
		ZONE_SLOW,
		ZONE_ONWARD
	} zone_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} tick_t;

	typedef struct packed {
		logic                 trigger;
		logic                 busy_res;
		logic                 done_res;
		logic [DIST_BITS-1:0] distance_cm;
		zone_t                zone;
		logic                 measured;
	} result_t;

endpackage

// ===== src/ultrasonic_range_zone_classifier_unit.sv =====
// Ultrasonic ranger controller with distance zone classification.
// Each transfer on the tick channel is one microsecond tick: a start request and
// the sampled echo level. Every tick produces exactly one transfer on the result
// channel, showing trigger, busy, done, the latest distance in cm, the zone and
// whether any measurement has completed since reset.
// A start taken while idle drives trigger low for two ticks, then high for ten,
// then waits for echo high and counts echo-high ticks. On the first low tick the
// distance (count / 58, kept as a running quotient while counting) is classified.
// The three thresholds are written through the cfg port; the user must write them
// only while the block is idle, which the block does not enforce. A tick's result
// is valid in the cycle after its transfer. Throughput is one tick per cycle, but
// when the receiver stalls, the result register holds and tick_ready drops until
// the held result is taken; a result taken in the same cycle frees the register.
// Reset returns the controller to idle, clears distance, zone and the measured
// flag, loads the default thresholds and empties the result register.
module ultrasonic_range_zone_classifier_unit
	import urzc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick_valid,
	output logic                    tick_ready,
	input  tick_t                   tick,
	output logic                    result_valid,
	input  logic                    result_ready,
	output result_t                 result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	phase_t                     phase_q, phase_d;
	logic [TICK_BITS-1:0]       ticks_q, ticks_d;
	logic [ECHO_COUNT_BITS-1:0] echo_q, echo_d;
	logic [REM_BITS-1:0]        rem_q, rem_d;
	logic [DIST_BITS-1:0]       quot_q, quot_d;
	logic [DIST_BITS-1:0]       dist_q, dist_d;
	zone_t                      zone_q, zone_d;
	logic                       meas_q, meas_d;
	logic                       done_d;
	logic [CFG_BITS-1:0]        stop_q, slow_q, onward_q;
	logic                       res_valid_q;
	result_t                    res_q;
	logic                       tick_fire;
	logic                       is_danger;

	assign tick_ready = !res_valid_q || result_ready;
	assign tick_fire = tick_valid && tick_ready;
	assign result_valid = res_valid_q;
	assign result = res_q;

	// Margin added on the distance side, so a threshold below the margin never matches.
	assign is_danger = ({1'b0, quot_q} + (DIST_BITS+1)'(DANGER_MARGIN))
		<= (DIST_BITS+1)'(stop_q);

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (tick.start_req) phase_d = PH_TLOW;
			end
			PH_TLOW: begin
				if (ticks_q >= TRIG_LOW_TICKS) phase_d = PH_THIGH;
			end
			PH_THIGH: begin
				if (ticks_q >= TRIG_HIGH_TICKS) phase_d = PH_WAIT;
			end
			PH_WAIT: begin
				if (tick.echo) phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				if (!tick.echo) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		ticks_d = ticks_q;
		echo_d = echo_q;
		rem_d = rem_q;
		quot_d = quot_q;
		dist_d = dist_q;
		zone_d = zone_q;
		meas_d = meas_q;
		done_d = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (tick.start_req) ticks_d = TICK_BITS'(1);
			end
			PH_TLOW: begin
				if (ticks_q >= TRIG_LOW_TICKS) ticks_d = TICK_BITS'(1);
				else ticks_d = ticks_q + TICK_BITS'(1);
			end
			PH_THIGH: begin
				if (ticks_q >= TRIG_HIGH_TICKS) ticks_d = '0;
				else ticks_d = ticks_q + TICK_BITS'(1);
			end
			PH_WAIT: begin
				if (tick.echo) begin
					echo_d = ECHO_COUNT_BITS'(1);
					rem_d = REM_BITS'(1);
					quot_d = '0;
				end
			end
			PH_COUNT: begin
				if (tick.echo) begin
					// The quotient by 58 advances each time the remainder wraps.
					if (echo_q != ECHO_MAX) begin
						echo_d = echo_q + ECHO_COUNT_BITS'(1);
						if (rem_q == REM_LAST) begin
							rem_d = '0;
							if (quot_q != DIST_MAX) quot_d = quot_q + DIST_BITS'(1);
						end else begin
							rem_d = rem_q + REM_BITS'(1);
						end
					end
				end else begin
					dist_d = quot_q;
					meas_d = 1'b1;
					done_d = 1'b1;
					ticks_d = '0;
					if (is_danger) zone_d = ZONE_DANGER;
					else if (quot_q <= DIST_BITS'(stop_q)) zone_d = ZONE_STOP;
					else if (quot_q <= DIST_BITS'(slow_q)) zone_d = ZONE_SLOW;
					else if (quot_q >= DIST_BITS'(onward_q)) zone_d = ZONE_ONWARD;
				end
			end
			default: ticks_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			echo_q <= '0;
			rem_q <= '0;
			quot_q <= '0;
			dist_q <= '0;
			zone_q <= ZONE_NONE;
			meas_q <= 1'b0;
		end else if (tick_fire) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			echo_q <= echo_d;
			rem_q <= rem_d;
			quot_q <= quot_d;
			dist_q <= dist_d;
			zone_q <= zone_d;
			meas_q <= meas_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= STOP_RESET;
			slow_q <= SLOW_RESET;
			onward_q <= ONWARD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STOP: stop_q <= cfg_data;
				CFG_SLOW: slow_q <= cfg_data;
				CFG_ONWARD: onward_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_fire) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			res_q.trigger <= (phase_d == PH_THIGH);
			res_q.busy_res <= (phase_d != PH_IDLE);
			res_q.done_res <= done_d;
			res_q.distance_cm <= dist_d;
			res_q.zone <= zone_d;
			res_q.measured <= meas_d;
		end
	end

endmodule

// ===== src/urzc_checker.sv =====
`include "ultrasonic_range_zone_classifier_unit_assert.svh"

module urzc_checker
	import urzc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    tick_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result stays put until it is taken.
	`URZC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// The tick channel is only held off by a stalled result.
	`URZC_ASSERT_NOW(a_ready_only_on_stall, !tick_ready, result_valid && !result_ready, "tick_ready low without a stalled result")

	// A completed measurement ends the busy period and sets the measured flag.
	`URZC_ASSERT_NOW(a_done_state, result_valid && result.done_res, result.measured && !result.busy_res, "done without measured or while busy")

	// Trigger is only driven during a measurement.
	`URZC_ASSERT_NOW(a_trigger_busy, result_valid && result.trigger, result.busy_res, "trigger high while idle")

	// A zone exists only after some measurement.
	`URZC_ASSERT_NOW(a_zone_measured, result_valid && (result.zone != ZONE_NONE), result.measured, "zone set before any measurement")

endmodule

bind ultrasonic_range_zone_classifier_unit urzc_checker u_urzc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
